>>> design/trimmed_mean_ntc_linearizer_assert.svh
// assertion macros for the trimmed mean ntc linearizer
`ifndef TRIMMED_MEAN_NTC_LINEARIZER_ASSERT_SVH
`define TRIMMED_MEAN_NTC_LINEARIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TMN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmn assertion failed");
`define TMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmn assertion failed");
`else
`define TMN_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TMN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/tmn_pkg.sv
// shared types, constants and ntc table for the trimmed mean ntc linearizer
package tmn_pkg;

  localparam int SAMPLE_W         = 12;
  localparam int TEMP_W           = 10;
  localparam int POWER_W          = 9;
  localparam int DEF_WINDOW_SIZE  = 10;
  localparam int DEF_KEEP_COUNT   = 5;
  localparam int TABLE_ENTRIES    = 64;
  localparam int FRACTION_SCALE   = 64;
  localparam int IDX_W            = $clog2(TABLE_ENTRIES);
  localparam int STEP_W           = $clog2(IDX_W + 1);
  localparam int FRAC_W           = $clog2(FRACTION_SCALE);
  localparam int QUO_W            = FRAC_W + 1;
  localparam int DIV_CNT_W        = $clog2(QUO_W + 1);
  localparam int SCALED_W         = $clog2((TABLE_ENTRIES + 1) * FRACTION_SCALE + 1);
  localparam int COLD_SCALED      = 2 * FRACTION_SCALE;
  localparam int HOT_SCALED       = (TABLE_ENTRIES + 1) * FRACTION_SCALE;
  localparam int DEG_OFFSET       = 3;
  localparam int TENTHS_MUL       = 10;
  localparam int MAINS_MUL        = 175;
  localparam int MAINS_DIV        = 2357;
  localparam int MAINS_SHIFT      = 32;
  localparam int MAINS_PROD_W     = SAMPLE_W + $clog2(MAINS_MUL + 1);
  localparam int MAINS_RECIP_W    = MAINS_SHIFT - $clog2(MAINS_DIV) + 1;
  localparam logic [MAINS_RECIP_W-1:0] MAINS_RECIP = MAINS_RECIP_W'(
    ((64'd1 << MAINS_SHIFT) + 64'(MAINS_DIV) - 64'd1) / 64'(MAINS_DIV));

  localparam logic [SAMPLE_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    12'd3426, 12'd3284, 12'd3149, 12'd3018, 12'd2895, 12'd2777, 12'd2664, 12'd2558,
    12'd2454, 12'd2353, 12'd2271, 12'd2192, 12'd2114, 12'd2039, 12'd1968, 12'd1898,
    12'd1831, 12'd1767, 12'd1704, 12'd1646, 12'd1614, 12'd1587, 12'd1531, 12'd1426,
    12'd1375, 12'd1328, 12'd1280, 12'd1235, 12'd1193, 12'd1150, 12'd1109, 12'd1071,
    12'd1033, 12'd996,  12'd962,  12'd928,  12'd895,  12'd864,  12'd834,  12'd803,
    12'd776,  12'd749,  12'd722,  12'd697,  12'd672,  12'd648,  12'd626,  12'd604,
    12'd582,  12'd562,  12'd541,  12'd522,  12'd505,  12'd487,  12'd469,  12'd453,
    12'd438,  12'd421,  12'd406,  12'd393,  12'd379,  12'd365,  12'd353,  12'd339
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] ntc_sample;
    logic [SAMPLE_W-1:0] mains_sample;
  } in_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temperature_tenths;
    logic [POWER_W-1:0] mains_power;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic acc_clr;
    logic acc_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
  } lin_stat_t;

endpackage

>>> design/tmn_sort_cell.sv
// one insertion sort cell: holds a sample, inserts or shifts toward cell zero
module tmn_sort_cell import tmn_pkg::*; (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                occupied,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] left_val,
  input  logic                left_gt,
  input  logic [SAMPLE_W-1:0] right_val,
  output logic [SAMPLE_W-1:0] val,
  output logic                gt
);

  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] val_nxt;

  // an empty cell acts as plus infinity
  assign gt  = !occupied || (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.insert) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt) begin
        val_nxt = sample;
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> design/tmn_sort_chain.sv
// row of sort cells with the trimmed sum accumulator at cell zero
module tmn_sort_chain import tmn_pkg::*; #(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
  parameter int KEEP_COUNT  = DEF_KEEP_COUNT,
  localparam int CNT_W      = $clog2(WINDOW_SIZE + 1),
  localparam int SUM_W      = $clog2(KEEP_COUNT * ((1 << SAMPLE_W) - 1) + 1)
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]    fill_cnt,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum
);

  logic [SAMPLE_W-1:0] vals [WINDOW_SIZE];
  logic                gts  [WINDOW_SIZE];
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    logic [SAMPLE_W-1:0] lv;
    logic [SAMPLE_W-1:0] rv;
    logic                lg;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_inner
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end

    if (i == WINDOW_SIZE - 1) begin : g_last
      assign rv = '0;
    end else begin : g_body
      assign rv = vals[i+1];
    end

    tmn_sort_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < fill_cnt),
      .sample    (sample),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.acc_clr) begin
      sum_nxt = '0;
    end else if (ctrl.acc_en) begin
      sum_nxt = sum_r + SUM_W'(vals[0]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

>>> design/tmn_linearize.sv
// ntc table search, serial interpolation divide and tenths conversion
module tmn_linearize import tmn_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] x,
  output lin_stat_t           stat,
  output logic [TEMP_W-1:0]   tenths
);

  localparam int TEN_W = SCALED_W + 4;

  typedef enum logic [2:0] {
    L_IDLE,
    L_SEARCH,
    L_PREP,
    L_DIV,
    L_SUB,
    L_FIN
  } lin_state_t;

  lin_state_t           state_r,   state_nxt;
  logic [SAMPLE_W-1:0]  x_r,       x_nxt;
  logic [IDX_W-1:0]     idx_r,     idx_nxt;
  logic [STEP_W-1:0]    step_r,    step_nxt;
  logic [SAMPLE_W-1:0]  diff_r,    diff_nxt;
  logic [SAMPLE_W-1:0]  rem_r,     rem_nxt;
  logic [QUO_W-1:0]     num_r,     num_nxt;
  logic [QUO_W-1:0]     quo_r,     quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [SCALED_W-1:0]  scaled_r,  scaled_nxt;
  logic [TEMP_W-1:0]    tenths_r,  tenths_nxt;

  logic [IDX_W-1:0]     cand;
  logic [SAMPLE_W-1:0]  hi_val;
  logic [SAMPLE_W-1:0]  x_delta;
  logic [SAMPLE_W:0]    rem_sh;
  logic                 quo_bit;
  logic [TEN_W-1:0]     tenths_full;

  assign cand        = idx_r | (IDX_W'(1) << step_r);
  assign hi_val      = NTC_ROM[idx_r + 1'b1];
  assign x_delta     = x_r - hi_val;
  assign rem_sh      = {rem_r, num_r[QUO_W-1]};
  assign quo_bit     = rem_sh >= {1'b0, diff_r};
  assign tenths_full = TEN_W'(scaled_r) * TEN_W'(TENTHS_MUL);

  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    diff_nxt    = diff_r;
    rem_nxt     = rem_r;
    num_nxt     = num_r;
    quo_nxt     = quo_r;
    div_cnt_nxt = div_cnt_r;
    scaled_nxt  = scaled_r;
    tenths_nxt  = tenths_r;
    case (state_r)
      L_IDLE: begin
        if (start) begin
          x_nxt = x;
          if (x > NTC_ROM[0]) begin
            scaled_nxt = SCALED_W'(COLD_SCALED);
            state_nxt  = L_FIN;
          end else if (x < NTC_ROM[TABLE_ENTRIES-1]) begin
            scaled_nxt = SCALED_W'(HOT_SCALED);
            state_nxt  = L_FIN;
          end else begin
            idx_nxt   = '0;
            step_nxt  = STEP_W'(IDX_W - 1);
            state_nxt = L_SEARCH;
          end
        end
      end
      L_SEARCH: begin
        if ((cand <= IDX_W'(TABLE_ENTRIES - 2)) && (NTC_ROM[cand] > x_r)) begin
          idx_nxt = cand;
        end
        if (step_r == '0) begin
          state_nxt = L_PREP;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      L_PREP: begin
        diff_nxt    = NTC_ROM[idx_r] - hi_val;
        rem_nxt     = {1'b0, x_delta[SAMPLE_W-1:1]};
        num_nxt     = {x_delta[0], {FRAC_W{1'b0}}};
        quo_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = L_DIV;
      end
      L_DIV: begin
        rem_nxt     = quo_bit ? SAMPLE_W'(rem_sh - {1'b0, diff_r}) : rem_sh[SAMPLE_W-1:0];
        quo_nxt     = {quo_r[QUO_W-2:0], quo_bit};
        num_nxt     = num_r << 1;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          state_nxt = L_SUB;
        end
      end
      L_SUB: begin
        scaled_nxt = ((SCALED_W'(idx_r) + SCALED_W'(DEG_OFFSET)) << FRAC_W)
                     - SCALED_W'(quo_r);
        state_nxt  = L_FIN;
      end
      L_FIN: begin
        tenths_nxt = TEMP_W'(tenths_full >> FRAC_W);
        state_nxt  = L_IDLE;
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r       <= x_nxt;
    idx_r     <= idx_nxt;
    step_r    <= step_nxt;
    diff_r    <= diff_nxt;
    rem_r     <= rem_nxt;
    num_r     <= num_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    scaled_r  <= scaled_nxt;
    tenths_r  <= tenths_nxt;
  end

  assign stat.busy = (state_r != L_IDLE);
  assign tenths    = tenths_r;

endmodule

>>> design/trimmed_mean_ntc_linearizer.sv
// top level: sample window sort chains, trimmed mean, ntc linearizer and mains scaling
// a window closes on its last sample transfer; its result then follows the cell drain,
// the six step table search and the seven step interpolation divide; clamped inputs skip
// the search and divide; in_ready stays low until the result is loaded into out_data
// reset: synchronous active low rst_n clears fill count, state and out_valid; cells keep data
module trimmed_mean_ntc_linearizer import tmn_pkg::*; #(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
  parameter int KEEP_COUNT  = DEF_KEEP_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "trimmed_mean_ntc_linearizer_assert.svh"

  localparam int CNT_W      = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W      = $clog2(KEEP_COUNT * ((1 << SAMPLE_W) - 1) + 1);
  localparam int TRIM_START = (WINDOW_SIZE - KEEP_COUNT + 1) / 2;
  localparam int TRIM_END   = TRIM_START + KEEP_COUNT - 1;
  localparam int DIVK_SHIFT = SUM_W + 4;
  localparam int RECIP_K_W  = DIVK_SHIFT + 1;
  localparam logic [RECIP_K_W-1:0] RECIP_K =
    RECIP_K_W'(((64'd1 << DIVK_SHIFT) + 64'(KEEP_COUNT) - 64'd1) / 64'(KEEP_COUNT));

  typedef enum logic [2:0] {
    S_FILL,
    S_DRAIN,
    S_DIVK,
    S_SCALE,
    S_MAINS,
    S_WAIT
  } state_t;

  state_t                    state_r,       state_nxt;
  logic [CNT_W-1:0]          fill_cnt_r,    fill_cnt_nxt;
  logic [CNT_W-1:0]          drain_cnt_r,   drain_cnt_nxt;
  logic [SAMPLE_W-1:0]       ntc_avg_r,     ntc_avg_nxt;
  logic [SAMPLE_W-1:0]       mains_avg_r,   mains_avg_nxt;
  logic [MAINS_PROD_W-1:0]   mains_prod_r,  mains_prod_nxt;
  logic [POWER_W-1:0]        mains_power_r, mains_power_nxt;
  logic                      out_valid_r,   out_valid_nxt;
  out_item_t                 out_data_r,    out_data_nxt;

  cell_ctrl_t                ctrl;
  logic                      in_xfer;
  logic                      out_load;
  logic                      lin_start;
  lin_stat_t                 lin_stat;
  logic [TEMP_W-1:0]         lin_tenths;
  logic [SUM_W-1:0]          ntc_sum;
  logic [SUM_W-1:0]          mains_sum;
  logic [SUM_W+RECIP_K_W-1:0] ntc_quot;
  logic [SUM_W+RECIP_K_W-1:0] mains_quot;
  logic [MAINS_PROD_W+MAINS_RECIP_W-1:0] mains_full;

  assign in_ready = (state_r == S_FILL);
  assign in_xfer  = in_valid && in_ready;

  tmn_sort_chain #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .KEEP_COUNT  (KEEP_COUNT)
  ) u_ntc_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .fill_cnt (fill_cnt_r),
    .sample   (in_data.ntc_sample),
    .sum      (ntc_sum)
  );

  tmn_sort_chain #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .KEEP_COUNT  (KEEP_COUNT)
  ) u_mains_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .fill_cnt (fill_cnt_r),
    .sample   (in_data.mains_sample),
    .sum      (mains_sum)
  );

  tmn_linearize u_lin (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lin_start),
    .x      (ntc_avg_r),
    .stat   (lin_stat),
    .tenths (lin_tenths)
  );

  assign ntc_quot   = (SUM_W + RECIP_K_W)'(ntc_sum) * (SUM_W + RECIP_K_W)'(RECIP_K);
  assign mains_quot = (SUM_W + RECIP_K_W)'(mains_sum) * (SUM_W + RECIP_K_W)'(RECIP_K);
  assign mains_full = (MAINS_PROD_W + MAINS_RECIP_W)'(mains_prod_r)
                      * (MAINS_PROD_W + MAINS_RECIP_W)'(MAINS_RECIP);

  always_comb begin
    state_nxt       = state_r;
    fill_cnt_nxt    = fill_cnt_r;
    drain_cnt_nxt   = drain_cnt_r;
    ntc_avg_nxt     = ntc_avg_r;
    mains_avg_nxt   = mains_avg_r;
    mains_prod_nxt  = mains_prod_r;
    mains_power_nxt = mains_power_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    ctrl            = '0;
    lin_start       = 1'b0;
    out_load        = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_FILL: begin
        if (in_xfer) begin
          ctrl.insert = 1'b1;
          if (fill_cnt_r == CNT_W'(WINDOW_SIZE - 1)) begin
            fill_cnt_nxt  = '0;
            drain_cnt_nxt = '0;
            ctrl.acc_clr  = 1'b1;
            state_nxt     = S_DRAIN;
          end else begin
            fill_cnt_nxt = fill_cnt_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        ctrl.shift  = 1'b1;
        ctrl.acc_en = (drain_cnt_r >= CNT_W'(TRIM_START));
        if (drain_cnt_r == CNT_W'(TRIM_END)) begin
          state_nxt = S_DIVK;
        end else begin
          drain_cnt_nxt = drain_cnt_r + 1'b1;
        end
      end
      S_DIVK: begin
        ntc_avg_nxt   = ntc_quot[DIVK_SHIFT +: SAMPLE_W];
        mains_avg_nxt = mains_quot[DIVK_SHIFT +: SAMPLE_W];
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        lin_start      = 1'b1;
        mains_prod_nxt = MAINS_PROD_W'(mains_avg_r) * MAINS_PROD_W'(MAINS_MUL);
        state_nxt      = S_MAINS;
      end
      S_MAINS: begin
        mains_power_nxt = mains_full[MAINS_SHIFT +: POWER_W];
        state_nxt       = S_WAIT;
      end
      S_WAIT: begin
        if (!lin_stat.busy && (!out_valid_r || out_ready)) begin
          out_load                        = 1'b1;
          out_valid_nxt                   = 1'b1;
          out_data_nxt.temperature_tenths = lin_tenths;
          out_data_nxt.mains_power        = mains_power_r;
          state_nxt                       = S_FILL;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_cnt_r  <= '0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ntc_avg_r     <= ntc_avg_nxt;
    mains_avg_r   <= mains_avg_nxt;
    mains_prod_r  <= mains_prod_nxt;
    mains_power_r <= mains_power_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TMN_ASSERT_SAME(a_fill_range, clk, rst_n, 1'b1, fill_cnt_r < CNT_W'(WINDOW_SIZE))
  `TMN_ASSERT_SAME(a_load_free, clk, rst_n, out_load, !out_valid_r || out_ready)
  `TMN_ASSERT_SAME(a_lin_idle_start, clk, rst_n, state_r == S_SCALE, !lin_stat.busy)
  `TMN_ASSERT_NEXT(a_window_close, clk, rst_n,
                   in_xfer && (fill_cnt_r == CNT_W'(WINDOW_SIZE - 1)), state_r == S_DRAIN)

endmodule
